// ----- rtl/core/mpeg_ps_pes_packetizer_assert.svh -----
// Assertion macros shared by the packetizer modules.
// Depends on nothing; included by the files that assert.
`ifndef MPEG_PS_PES_PACKETIZER_ASSERT_SVH
`define MPEG_PS_PES_PACKETIZER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MPP_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MPP_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/mpp_pkg.sv -----
// Package for the program stream packetizer: types, constants, header table.
// Depends on nothing.
package mpp_pkg;
    localparam logic [32:0] M_TS_DELTA = 33'd3600;
    localparam logic [8:0]  SCR_EXT_DIV = 9'd300;

    // Configuration register indexes.
    localparam logic [1:0] REG_VOFF = 2'd0;
    localparam logic [1:0] REG_AOFF = 2'd1;
    localparam logic [1:0] REG_MUX  = 2'd2;

    typedef enum logic [2:0] {
        OP_ERROR  = 3'd0,
        OP_PACK   = 3'd1,
        OP_IFRAME = 3'd2,
        OP_PES    = 3'd3,
        OP_BYTE   = 3'd4
    } t_op;

    // One command from the classifier to the byte generator.
    typedef struct packed {
        t_op         op;
        logic        audio;
        logic        real_ts;
        logic [16:0] plen;
        logic [32:0] stamp;
        logic [7:0]  data;
        logic        last;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_PACK = 3'd1,
        S_SYS  = 3'd2,
        S_MAP  = 3'd3,
        S_PES  = 3'd4,
        S_BYTE = 3'd5
    } t_gen_state;

    function automatic logic [7:0] f_map_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0: b = 8'h00;  5'd1: b = 8'h00;  5'd2: b = 8'h01;  5'd3: b = 8'hBC;
            5'd4: b = 8'h00;  5'd5: b = 8'h18;  5'd6: b = 8'hE1;  5'd7: b = 8'hFF;
            5'd8: b = 8'h00;  5'd9: b = 8'h00;  5'd10: b = 8'h00; 5'd11: b = 8'h08;
            5'd12: b = 8'h1B; 5'd13: b = 8'hE0; 5'd14: b = 8'h00; 5'd15: b = 8'h06;
            5'd16: b = 8'h0A; 5'd17: b = 8'h04; 5'd18: b = 8'h65; 5'd19: b = 8'h6E;
            5'd20: b = 8'h67; 5'd21: b = 8'h00; 5'd22: b = 8'h90; 5'd23: b = 8'hC0;
            5'd24: b = 8'h00; 5'd25: b = 8'h00; 5'd26: b = 8'h23; 5'd27: b = 8'hB9;
            5'd28: b = 8'h0F; 5'd29: b = 8'h3D;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] f_sys_tail(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0: b = 8'hFE; 4'd1: b = 8'hE1; 4'd2: b = 8'h7F; 4'd3: b = 8'hE0;
            4'd4: b = 8'hE0; 4'd5: b = 8'hD8; 4'd6: b = 8'hC0; 4'd7: b = 8'hC0;
            4'd8: b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // One byte of a 5-byte PTS/DTS field.
    function automatic logic [7:0] f_ts_byte(input logic [32:0] v, input logic [7:0] pfx,
                                             input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0: b = {4'h0, v[32:30], 1'b0} | pfx;
            3'd1: b = v[29:22];
            3'd2: b = {v[21:15], 1'b1};
            3'd3: b = v[14:7];
            3'd4: b = {v[6:0], 1'b1};
            default: b = 8'h00;
        endcase
        return b;
    endfunction
endpackage

// ----- rtl/core/mpp_stream_if.sv -----
// Valid/ready stream interface with a generic payload type.
// Depends on nothing.
interface mpp_stream_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/mpp_in_t.sv -----
// Input and output payload structs for the packetizer channels.
// Depends on nothing.
package mpp_io_pkg;
    typedef struct packed {
        logic        kind;
        logic [1:0]  frame_type;
        logic [32:0] pts;
        logic [23:0] frame_len;
        logic [7:0]  data_byte;
    } t_in_item;
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       error;
    } t_out_item;
endpackage

// ----- rtl/core/mpp_front.sv -----
// Front end: accepts items, tracks frame state and issues commands.
// Depends on mpp_pkg and mpp_io_pkg.
module mpp_front
    import mpp_pkg::*;
    import mpp_io_pkg::*;
#(
    parameter int CHUNK_BYTES = 61440
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_in_item        i_item,
    input  logic [32:0]     i_video_off,
    input  logic [32:0]     i_audio_off,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output t_cmd            o_cmd
);
    localparam logic [23:0] CHUNK = 24'(CHUNK_BYTES);

    logic        r_open, n_open;
    logic        r_audio, n_audio;
    logic [23:0] r_left, n_left;
    logic [15:0] r_chunk, n_chunk;
    logic        r_first, n_first;
    logic [32:0] r_stamp, n_stamp;
    t_cmd        c;
    logic        acc;
    logic [23:0] cl;
    logic        a;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign acc         = i_valid & i_cmd_ready;
    assign o_cmd       = c;

    always_comb begin
        n_open = r_open; n_audio = r_audio; n_left = r_left;
        n_chunk = r_chunk; n_first = r_first; n_stamp = r_stamp;
        c = '0;
        c.op = OP_ERROR;
        a = i_item.frame_type[1];
        cl = r_left;
        if (!i_item.kind) begin
            n_open = 1'b0; n_chunk = '0;
            if (i_item.frame_len == '0 || (a && i_item.frame_len > 24'd65522)) begin
                c.op = OP_ERROR;
            end else begin
                n_audio = a;
                n_stamp = i_item.pts + (a ? i_audio_off : i_video_off);
                n_left  = i_item.frame_len;
                n_first = 1'b1;
                n_open  = 1'b1;
                c.stamp = n_stamp;
                if (a) c.op = OP_BYTE;
                else if (i_item.frame_type[0]) c.op = OP_PACK;
                else c.op = OP_IFRAME;
                // An audio start emits nothing; marked with op BYTE and real_ts clear.
                c.real_ts = ~a;
            end
        end else if (!r_open || r_left == '0) begin
            c.op = OP_ERROR;
        end else begin
            c.op = OP_PES;
            c.audio = r_audio;
            c.stamp = r_stamp;
            c.data = i_item.data_byte;
            c.real_ts = 1'b0;
            if (r_chunk == '0) begin
                if (!r_audio && r_left > CHUNK) cl = CHUNK;
                c.real_ts = r_audio | r_first;
                c.plen = {1'b1, 16'(cl + 24'd13)};
                n_first = 1'b0;
                n_chunk = 16'(cl) - 16'd1;
            end else begin
                n_chunk = r_chunk - 16'd1;
            end
            n_left = r_left - 24'd1;
            c.last = (n_left == '0);
            if (c.last) begin
                n_open = 1'b0; n_chunk = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0; r_audio <= 1'b0; r_left <= '0;
            r_chunk <= '0; r_first <= 1'b1; r_stamp <= '0;
        end else if (acc) begin
            r_open <= n_open; r_audio <= n_audio; r_left <= n_left;
            r_chunk <= n_chunk; r_first <= n_first; r_stamp <= n_stamp;
        end
    end
endmodule

// ----- rtl/core/mpp_queue.sv -----
// Two-entry command queue between front and back end.
// Depends on mpp_pkg.
module mpp_queue
    import mpp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign wr = i_valid & o_ready;
    assign rd = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    `include "mpeg_ps_pes_packetizer_assert.svh"
    `MPP_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, r_cnt == 2'd2, !wr)
    `MPP_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, wr && !rd, r_cnt != 2'd0)
    `MPP_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
endmodule

// ----- rtl/core/mpp_back.sv -----
// Back end: expands commands into program stream bytes with a skid-free
// output register. Depends on mpp_pkg and mpp_io_pkg.
module mpp_back
    import mpp_pkg::*;
    import mpp_io_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    input  logic [21:0] i_prog_rate,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item
);
    t_gen_state  r_st, n_st;
    logic [5:0]  r_idx, n_idx;
    t_cmd        r_cmd, n_cmd;
    logic [32:0] r_scr;
    logic [24:0] r_x1;
    logic [20:0] r_x2, r_x3;
    logic [12:0] r_q;
    logic [41:0] rp;
    logic [8:0]  scr_ext;
    logic        r_ov, n_ov;
    t_out_item   r_o, n_o;
    logic        take, adv, start;
    logic [7:0]  b;
    logic        fin;
    logic [32:0] s;
    logic [32:0] dts;
    logic [4:0]  pi;

    assign o_valid = r_ov;
    assign o_item  = r_o;
    assign adv     = !r_ov || i_ready;
    assign o_ready = adv && (r_st == S_IDLE);
    assign take    = i_valid && o_ready;
    assign s       = i_cmd.stamp - M_TS_DELTA;

    // The SCR remainder mod 300 is folded down over the free-running registers r_x1,
    // r_x2, r_x3 and r_q: 2^16 mod 300 is 136 and 2^12 mod 300 is 196, and the last
    // 21-bit value is divided by a reciprocal multiply that is exact over that range.
    // The result settles through these registers after a start, well before pack byte 8.
    assign rp      = 42'(r_x2) * 42'd1789570;
    assign scr_ext = 9'(r_x3 - 21'(r_q) * 21'(SCR_EXT_DIV));

    assign dts = r_cmd.stamp - M_TS_DELTA;
    assign pi  = 5'(r_idx);

    always_comb begin
        n_st = r_st; n_idx = r_idx; n_cmd = r_cmd;
        n_ov = r_ov && !i_ready; n_o = r_o;
        b = 8'h00; fin = 1'b0;
        start = 1'b0;
        if (take) begin
            n_cmd = i_cmd; n_idx = '0;
            case (i_cmd.op)
                OP_ERROR: begin
                    n_ov = 1'b1; n_o = '{out_byte: 8'h00, out_last: 1'b0, error: 1'b1};
                end
                OP_PACK, OP_IFRAME: begin n_st = S_PACK; start = 1'b1; end
                OP_PES: begin
                    // A byte inside a packet goes straight to the output register.
                    if (i_cmd.plen[16]) begin
                        n_st = S_PES;
                    end else begin
                        n_ov = 1'b1;
                        n_o = '{out_byte: i_cmd.data, out_last: i_cmd.last, error: 1'b0};
                    end
                end
                default: ;
            endcase
        end else if (adv && r_st != S_IDLE) begin
            case (r_st)
                S_PACK: begin
                    case (r_idx[3:0])
                        4'd0, 4'd1: b = 8'h00;
                        4'd2: b = 8'h01;
                        4'd3: b = 8'hBA;
                        4'd4: b = {2'b01, r_scr[32:30], 1'b1, r_scr[29:28]};
                        4'd5: b = r_scr[27:20];
                        4'd6: b = {r_scr[19:15], 1'b1, r_scr[14:13]};
                        4'd7: b = r_scr[12:5];
                        4'd8: b = {r_scr[4:0], 1'b1, scr_ext[8:7]};
                        4'd9: b = {scr_ext[6:0], 1'b1};
                        4'd10: b = i_prog_rate[21:14];
                        4'd11: b = i_prog_rate[13:6];
                        4'd12: b = {i_prog_rate[5:0], 2'b11};
                        default: b = 8'hF8;
                    endcase
                    fin = (r_idx == 6'd13);
                    if (fin) n_st = (r_cmd.op == OP_IFRAME) ? S_SYS : S_IDLE;
                end
                S_SYS: begin
                    case (r_idx[4:0])
                        5'd0, 5'd1, 5'd4: b = 8'h00;
                        5'd2: b = 8'h01;
                        5'd3: b = 8'hBB;
                        5'd5: b = 8'h0C;
                        5'd6: b = {1'b1, i_prog_rate[21:15]};
                        5'd7: b = i_prog_rate[14:7];
                        5'd8: b = {i_prog_rate[6:0], 1'b1};
                        default: b = f_sys_tail(4'(r_idx - 6'd9));
                    endcase
                    fin = (r_idx == 6'd17);
                    if (fin) n_st = S_MAP;
                end
                S_MAP: begin
                    b = f_map_byte(pi);
                    fin = (r_idx == 6'd29);
                    if (fin) n_st = S_IDLE;
                end
                S_PES: begin
                    if (!r_cmd.plen[16]) begin
                        n_st = S_BYTE;
                    end else begin
                        case (r_idx[4:0])
                            5'd0, 5'd1: b = 8'h00;
                            5'd2: b = 8'h01;
                            5'd3: b = r_cmd.audio ? 8'hC0 : 8'hE0;
                            5'd4: b = r_cmd.plen[15:8];
                            5'd5: b = r_cmd.plen[7:0];
                            5'd6: b = 8'h80;
                            5'd7: b = 8'hC0;
                            5'd8: b = 8'h0A;
                            default: begin
                                if (r_idx < 6'd14)
                                    b = f_ts_byte(r_cmd.real_ts ? r_cmd.stamp : '0,
                                                  8'h31, 3'(r_idx - 6'd9));
                                else
                                    b = f_ts_byte(r_cmd.real_ts ? dts : '0,
                                                  8'h11, 3'(r_idx - 6'd14));
                            end
                        endcase
                        fin = (r_idx == 6'd18);
                        if (fin) n_st = S_BYTE;
                    end
                    if (r_cmd.plen[16]) begin
                        n_ov = 1'b1; n_o = '{out_byte: b, out_last: 1'b0, error: 1'b0};
                    end
                end
                S_BYTE: begin
                    n_ov = 1'b1;
                    n_o = '{out_byte: r_cmd.data, out_last: r_cmd.last, error: 1'b0};
                    n_st = S_IDLE;
                end
                default: n_st = S_IDLE;
            endcase
            if (r_st == S_PACK || r_st == S_SYS || r_st == S_MAP) begin
                n_ov = 1'b1; n_o = '{out_byte: b, out_last: 1'b0, error: 1'b0};
            end
            n_idx = fin ? '0 : r_idx + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_o   <= n_o;
        r_idx <= n_idx;
        if (start) r_scr <= s;
        r_x1 <= 25'(r_scr[32:16]) * 25'd136 + 25'(r_scr[15:0]);
        r_x2 <= 21'(r_x1[24:12]) * 21'd196 + 21'(r_x1[11:0]);
        r_x3 <= r_x2;
        r_q  <= rp[41:29];
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_ov <= n_ov;
        end
    end

    `include "mpeg_ps_pes_packetizer_assert.svh"
    `MPP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ov && !i_ready, r_ov && $stable(r_o))
    `MPP_ASSERT_IMPL(a_idle_take, i_clk, i_rst_n, take, r_st == S_IDLE)
    `MPP_ASSERT_IMPL(a_err_clean, i_clk, i_rst_n, r_ov && r_o.error,
                     r_o.out_byte == 8'h00 && !r_o.out_last)
endmodule

// ----- rtl/core/mpeg_ps_pes_packetizer.sv -----
// Top level of the MPEG-2 program stream PES packetizer.
// Depends on mpp_pkg, mpp_io_pkg, mpp_stream_if, mpp_front, mpp_queue, mpp_back.
//
// Usage: items enter on the in_ch sink channel; each is a frame start (kind 0)
// or one payload byte (kind 1). Output bytes leave on the out_ch source
// channel with out_last on the final payload byte of a frame and error on a
// rejected item. Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write them only while the block is idle, as the block does not enforce this.
// A payload byte inside a PES packet goes straight to the output register. The byte
// generator emits one byte per cycle while the receiver does not stall, after it takes
// a header request, so a packet's first byte follows 19 header bytes, a P start gives
// 14 pack header bytes, an I start 62 header bytes and an audio start no bytes.
// From acceptance, a payload byte or an error passes the queue and the output
// register, and a header passes the generator state register as well.
// A two-entry command queue lets input be taken while the generator works.
// Reset clears frame state, the queue and the output register and loads the
// register reset values. When the receiver stalls, the output register holds
// its byte and the queue fills, after which input ready drops.
module mpeg_ps_pes_packetizer
    import mpp_pkg::*;
    import mpp_io_pkg::*;
#(
    parameter int CHUNK_BYTES = 61440
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpp_stream_if.sink   in_ch,
    mpp_stream_if.source out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [32:0] i_cfg_data
);
    logic [32:0] r_voff, r_aoff;
    logic [21:0] r_mux;
    logic        f_v, f_r, q_v, q_r;
    t_cmd        f_c, q_c;
    t_out_item   o_it;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voff <= 33'd3600; r_aoff <= 33'd3600; r_mux <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_VOFF: r_voff <= i_cfg_data;
                REG_AOFF: r_aoff <= i_cfg_data;
                REG_MUX:  r_mux  <= i_cfg_data[21:0];
                default: ;
            endcase
        end
    end

    mpp_front #(.CHUNK_BYTES(CHUNK_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_item(in_ch.data), .i_video_off(r_voff), .i_audio_off(r_aoff),
        .o_cmd_valid(f_v), .i_cmd_ready(f_r), .o_cmd(f_c)
    );

    mpp_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_cmd(f_c),
        .o_valid(q_v), .i_ready(q_r), .o_cmd(q_c)
    );

    mpp_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_ready(q_r), .i_cmd(q_c),
        .i_prog_rate(r_mux), .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_item(o_it)
    );

    assign out_ch.data = o_it;
endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the program stream packetizer: drives frame starts and
// payload bytes, predicts every output byte and compares field by field.
// Depends on mpp_pkg, mpp_io_pkg, mpp_stream_if and mpeg_ps_pes_packetizer.
module tb_top;
    import mpp_pkg::*;
    import mpp_io_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CHUNK_LEN   = 61440;
    localparam logic [1:0]  FT_I        = 2'd0;
    localparam logic [1:0]  FT_P        = 2'd1;
    localparam logic [1:0]  FT_AUDIO    = 2'd2;
    localparam logic [1:0]  FT_ALT_AUD  = 2'd3;
    localparam logic        K_START     = 1'b0;
    localparam logic        K_BYTE      = 1'b1;
    localparam logic [32:0] TS_MAX      = 33'h1_FFFF_FFFF;
    localparam logic [23:0] AUDIO_MAX   = 24'd65522;
    localparam int          ITEM_GOAL   = 500;

    typedef struct {
        logic        kind;
        logic [1:0]  ftype;
        logic [32:0] pts;
        logic [23:0] len;
        logic [7:0]  data;
        bit          is_err;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [32:0] i_cfg_data;

    mpp_stream_if #(.T(t_in_item))  in_ch  (i_clk);
    mpp_stream_if #(.T(t_out_item)) out_ch (i_clk);

    mpeg_ps_pes_packetizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor copy of the registers and frame state.
    logic [32:0] vid_ofs, aud_ofs;
    logic [21:0] prog_rate;
    logic [1:0]  open_type;
    logic        frame_open;
    logic [23:0] bytes_left;
    logic [15:0] chunk_left;
    logic        first_chunk;
    logic [32:0] stamp;

    t_out_item  ps_bytes_q[$];
    t_stim_row  stim_tab[$];
    int         n_mismatch;
    int         n_fail;
    int         n_items;
    int         n_seen;
    bit         send_calm;
    bit         recv_calm;
    bit         hold_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #8ms;
        $display("Some tests failed");
        $finish;
    end

    task automatic emit(input logic [7:0] b, input logic last = 1'b0,
                        input logic err = 1'b0);
        t_out_item o;
        o.out_byte = b;
        o.out_last = last;
        o.error    = err;
        ps_bytes_q.push_back(o);
    endtask

    task automatic emit_stamp(input logic [32:0] v, input logic [7:0] pfx);
        emit({4'h0, v[32:30], 1'b0} | pfx);
        emit(v[29:22]);
        emit({v[21:15], 1'b1});
        emit(v[14:7]);
        emit({v[6:0], 1'b1});
    endtask

    task automatic emit_pack_header();
        logic [32:0] scr;
        logic [32:0] ext;
        scr = stamp - 33'd3600;
        ext = scr % 300;
        emit(8'h00); emit(8'h00); emit(8'h01); emit(8'hBA);
        emit({2'b01, scr[32:30], 1'b1, scr[29:28]});
        emit(scr[27:20]);
        emit({scr[19:15], 1'b1, scr[14:13]});
        emit(scr[12:5]);
        emit({scr[4:0], 1'b1, ext[8:7]});
        emit({ext[6:0], 1'b1});
        emit(prog_rate[21:14]);
        emit(prog_rate[13:6]);
        emit({prog_rate[5:0], 2'b11});
        emit(8'hF8);
    endtask

    task automatic emit_iframe_headers();
        logic [7:0] map_b[30] = '{8'h00, 8'h00, 8'h01, 8'hBC, 8'h00, 8'h18, 8'hE1, 8'hFF,
                                 8'h00, 8'h00, 8'h00, 8'h08, 8'h1B, 8'hE0, 8'h00, 8'h06,
                                 8'h0A, 8'h04, 8'h65, 8'h6E, 8'h67, 8'h00, 8'h90, 8'hC0,
                                 8'h00, 8'h00, 8'h23, 8'hB9, 8'h0F, 8'h3D};
        logic [7:0] tail_b[9] = '{8'hFE, 8'hE1, 8'h7F, 8'hE0, 8'hE0, 8'hD8, 8'hC0,
                                  8'hC0, 8'h20};
        emit(8'h00); emit(8'h00); emit(8'h01); emit(8'hBB); emit(8'h00); emit(8'h0C);
        emit({1'b1, prog_rate[21:15]});
        emit(prog_rate[14:7]);
        emit({prog_rate[6:0], 1'b1});
        foreach (tail_b[k]) emit(tail_b[k]);
        foreach (map_b[k]) emit(map_b[k]);
    endtask

    // Appends the program stream bytes that one accepted request produces.
    task automatic packetize_item(input t_in_item it);
        logic        is_audio;
        logic [23:0] cnt;
        logic [15:0] plen;
        if (it.kind == K_START) begin
            is_audio   = it.frame_type[1];
            frame_open = 1'b0;
            chunk_left = '0;
            if (it.frame_len == 0 || (is_audio && it.frame_len > AUDIO_MAX)) begin
                emit(8'h00, 1'b0, 1'b1);
                return;
            end
            open_type   = is_audio ? FT_AUDIO : it.frame_type;
            stamp       = it.pts + (is_audio ? aud_ofs : vid_ofs);
            bytes_left  = it.frame_len;
            first_chunk = 1'b1;
            frame_open  = 1'b1;
            if (!is_audio) begin
                emit_pack_header();
                if (it.frame_type == FT_I) emit_iframe_headers();
            end
            return;
        end
        if (!frame_open || bytes_left == 0) begin
            emit(8'h00, 1'b0, 1'b1);
            return;
        end
        is_audio = (open_type == FT_AUDIO);
        if (chunk_left == 0) begin
            cnt = bytes_left;
            if (!is_audio && cnt > CHUNK_LEN) cnt = CHUNK_LEN;
            plen = 16'(cnt + 24'd13);
            emit(8'h00); emit(8'h00); emit(8'h01);
            emit(is_audio ? 8'hC0 : 8'hE0);
            emit(plen[15:8]); emit(plen[7:0]);
            emit(8'h80); emit(8'hC0); emit(8'h0A);
            // Continuation packets of a video frame carry zero time stamps.
            if (is_audio || first_chunk) begin
                emit_stamp(stamp, 8'h31);
                emit_stamp(stamp - 33'd3600, 8'h11);
            end else begin
                emit_stamp('0, 8'h31);
                emit_stamp('0, 8'h11);
            end
            first_chunk = 1'b0;
            chunk_left  = cnt[15:0];
        end
        chunk_left = chunk_left - 1'b1;
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) begin
            frame_open = 1'b0;
            chunk_left = '0;
            emit(it.data_byte, 1'b1);
        end else begin
            emit(it.data_byte);
        end
    endtask

    task automatic send_item(input t_in_item it, input bit is_err = 1'b0);
        int gap;
        int depth;
        @(negedge i_clk);
        gap = send_calm ? 0 : $urandom_range(3);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        do @(posedge i_clk); while (!in_ch.ready);
        depth = ps_bytes_q.size();
        packetize_item(it);
        // Rejected requests have a fixed, obvious answer.
        if (is_err) begin
            while (ps_bytes_q.size() > depth) void'(ps_bytes_q.pop_back());
            emit(8'h00, 1'b0, 1'b1);
        end
        n_items++;
        if ($urandom_range(31) == 0) send_calm = ~send_calm;
    endtask

    function automatic t_in_item make_item(input logic kind, input logic [1:0] ftype,
                                           input logic [32:0] pts, input logic [23:0] len,
                                           input logic [7:0] data);
        t_in_item it;
        it.kind       = kind;
        it.frame_type = ftype;
        it.pts        = pts;
        it.frame_len  = len;
        it.data_byte  = data;
        return it;
    endfunction

    function automatic logic [32:0] rand_ts();
        return {1'($urandom_range(1)), 32'($urandom)};
    endfunction

    task automatic add_row(input logic kind, input logic [1:0] ftype, input logic [32:0] pts,
                           input logic [23:0] len, input logic [7:0] data,
                           input bit is_err = 1'b0);
        t_stim_row r;
        r.kind   = kind;
        r.ftype  = ftype;
        r.pts    = pts;
        r.len    = len;
        r.data   = data;
        r.is_err = is_err;
        stim_tab.push_back(r);
    endtask

    task automatic send_payload(input int count);
        repeat (count)
            send_item(make_item(K_BYTE, 2'($urandom), rand_ts(), 24'($urandom), 8'($urandom)));
    endtask

    // Waits for the pipeline to drain before a register write.
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (ps_bytes_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [32:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_VOFF: vid_ofs   = val;
            REG_AOFF: aud_ofs   = val;
            REG_MUX:  prog_rate = val[21:0];
            default: ;
        endcase
    endtask

    task automatic random_traffic(input int goal);
        int pick;
        int len;
        logic [1:0] ft;
        while (n_items < goal) begin
            pick = $urandom_range(99);
            ft   = 2'($urandom);
            if (pick < 78) begin
                len = $urandom_range(1, (ft[1] || $urandom_range(3) == 0) ? 8 : 3);
                send_item(make_item(K_START, ft, rand_ts(), 24'(len), 8'($urandom)));
                // Now and then the frame is cut short and the next start abandons it.
                send_payload(($urandom_range(9) == 0) ? $urandom_range(len - 1) : len);
            end else if (pick < 86) begin
                send_item(make_item(K_BYTE, ft, rand_ts(), 24'($urandom), 8'($urandom)));
            end else if (pick < 92) begin
                send_item(make_item(K_START, ft, rand_ts(), 24'd0, 8'($urandom)));
            end else begin
                send_item(make_item(K_START, ft, rand_ts(), 24'($urandom), 8'($urandom)));
                send_payload($urandom_range(3));
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_seen++;
            if (ps_bytes_q.size() == 0) begin
                n_fail++;
                if (n_mismatch++ < 10)
                    $display("unexpected output byte %h last %b err %b", out_ch.data.out_byte,
                             out_ch.data.out_last, out_ch.data.error);
            end else begin
                want = ps_bytes_q.pop_front();
                if (out_ch.data.out_byte !== want.out_byte
                        || out_ch.data.out_last !== want.out_last
                        || out_ch.data.error !== want.error) begin
                    n_fail++;
                    if (n_mismatch++ < 10)
                        $display("mismatch at output %0d: expected %h/%b/%b got %h/%b/%b",
                                 n_seen, want.out_byte, want.out_last, want.error,
                                 out_ch.data.out_byte, out_ch.data.out_last,
                                 out_ch.data.error);
                end
            end
        end
    end

    // Output side: random stalls, calm stretches and one long hold-off.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = recv_calm ? 0 : $urandom_range(3);
            if (!hold_done && n_seen >= 200) begin
                hold_done = 1'b1;
                stall     = 400;
            end
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if ($urandom_range(63) == 0) recv_calm = ~recv_calm;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_VOFF;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        n_mismatch  = 0;
        n_fail      = 0;
        n_items     = 0;
        n_seen      = 0;
        send_calm   = 1'b0;
        recv_calm   = 1'b0;
        hold_done   = 1'b0;
        vid_ofs     = 33'd3600;
        aud_ofs     = 33'd3600;
        prog_rate   = '0;
        open_type   = FT_I;
        frame_open  = 1'b0;
        bytes_left  = '0;
        chunk_left  = '0;
        first_chunk = 1'b1;
        stamp       = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Rejected requests: stray byte, zero length, audio too long for one packet.
        add_row(K_BYTE,  FT_I,       '0,     24'd5,     8'hFF, 1'b1);
        add_row(K_START, FT_I,       TS_MAX, 24'd0,     8'h00, 1'b1);
        add_row(K_START, FT_AUDIO,   '0,     24'd65523, 8'h00, 1'b1);
        add_row(K_START, FT_ALT_AUD, TS_MAX, 24'hFFFFFF, 8'h00, 1'b1);
        add_row(K_START, FT_I,       TS_MAX, 24'd2,     8'h00);
        add_row(K_BYTE,  FT_I,       '0,     '0,        8'h00);
        add_row(K_BYTE,  FT_I,       '0,     '0,        8'hFF);
        add_row(K_BYTE,  FT_I,       '0,     '0,        8'h5A, 1'b1);
        add_row(K_START, FT_P,       '0,     24'd1,     8'h00);
        add_row(K_BYTE,  FT_P,       '0,     '0,        8'hAA);
        add_row(K_START, FT_AUDIO,   TS_MAX, AUDIO_MAX, 8'h00);
        add_row(K_BYTE,  FT_AUDIO,   '0,     '0,        8'h55);
        // A new start abandons the open audio frame.
        add_row(K_START, FT_ALT_AUD, 33'd7,  24'd2,     8'h00);
        add_row(K_BYTE,  FT_AUDIO,   '0,     '0,        8'h01);
        add_row(K_BYTE,  FT_AUDIO,   '0,     '0,        8'h02);
        add_row(K_START, FT_P,       33'd3599, 24'hFFFFFF, 8'h00);
        add_row(K_BYTE,  FT_P,       '0,     '0,        8'h80);
        add_row(K_START, FT_I,       33'd1,  24'd1,     8'h00);
        add_row(K_BYTE,  FT_I,       '0,     '0,        8'h7F);
        foreach (stim_tab[k])
            send_item(make_item(stim_tab[k].kind, stim_tab[k].ftype, stim_tab[k].pts,
                                stim_tab[k].len, stim_tab[k].data), stim_tab[k].is_err);
        random_traffic(ITEM_GOAL / 4);

        wait_idle();
        write_reg(REG_VOFF, TS_MAX);
        write_reg(REG_AOFF, TS_MAX);
        write_reg(REG_MUX, 33'h3F_FFFF);
        random_traffic(ITEM_GOAL / 2);

        wait_idle();
        write_reg(REG_VOFF, '0);
        write_reg(REG_AOFF, '0);
        write_reg(REG_MUX, '0);
        random_traffic(3 * ITEM_GOAL / 4);

        wait_idle();
        write_reg(REG_VOFF, rand_ts());
        write_reg(REG_AOFF, rand_ts());
        write_reg(REG_MUX, 33'($urandom));
        random_traffic(ITEM_GOAL);

        wait_idle();
        repeat (30) @(negedge i_clk);
        if (n_fail == 0 && ps_bytes_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
